>>> sv/gso_pkg.sv
// Shared constants, command codes and divider interface types for the grid sweep odometer.
package gso_pkg;

   localparam int MAX_DIMS     = 4;
   localparam int MAX_STEPS    = 1024;
   localparam int VALUE_BITS   = 32;
   localparam int DIM_BITS     = 2;
   localparam int ACTIVE_BITS  = 3;
   localparam int CMD_BITS     = 3;
   localparam int COUNT_BITS   = $clog2(MAX_STEPS + 1);
   localparam int DIV_BITS     = $clog2(MAX_STEPS);
   localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int TOTAL_BITS   = 41;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_NEXT      = 3'd0,
      CMD_RESTART   = 3'd1,
      CMD_SET_LOWER = 3'd2,
      CMD_SET_UPPER = 3'd3,
      CMD_SET_COUNT = 3'd4,
      CMD_FIX_VALUE = 3'd5
   } cmd_type;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [DIV_BITS-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

>>> sv/gso_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module gso_divider
   import gso_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [VALUE_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_BITS-1:0]     divisor_ff, divisor_in;

   logic [DIV_BITS:0] trial;
   logic [DIV_BITS:0] trial_diff;
   logic              fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[VALUE_BITS-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_BITS'(VALUE_BITS);
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits shift in at the bottom.
         rem_in = fits ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> sv/grid_sweep_odometer.sv
// Grid sweep odometer: steps up to four Q16.16 parameters over an evenly spaced grid,
// dimension 0 fastest. One transaction is handled at a time. A next command walks the carry
// chain one dimension at a time through a single saturating adder, or goes straight to the
// result once the sweep has run past its end. A restart or accepted set command computes
// each active dimension's increment in turn through the shared bit-serial divider (issue,
// the quotient iterations and the done step). A rejected command goes straight to the
// result. A stalled result holds the block until the receiver takes it. A write of
// active_dims sets all bounds to zero and all counts to one, and holds off the request
// channel while csr_valid is high.
module grid_sweep_odometer
   import gso_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CMD_BITS-1:0]          req_command,
   input  logic [DIM_BITS-1:0]          req_dim_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [COUNT_BITS-1:0]        req_step_count,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic signed [VALUE_BITS-1:0] rsp_value_0,
   output logic signed [VALUE_BITS-1:0] rsp_value_1,
   output logic signed [VALUE_BITS-1:0] rsp_value_2,
   output logic signed [VALUE_BITS-1:0] rsp_value_3,
   output logic                         rsp_is_first,
   output logic                         rsp_is_last,
   output logic                         rsp_has_next,
   output logic                         rsp_has_tuples,
   output logic [TOTAL_BITS-1:0]        rsp_total_tuples,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ACTIVE_BITS-1:0]       csr_active_dims
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SETUP_ISSUE,
      ST_SETUP_WAIT,
      ST_FINISH
   } state_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   state_type              state_ff, state_in;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [DIM_BITS-1:0]    dim_ff, dim_in;
   logic                   ok_ff, ok_in;
   logic                   neg_ff, neg_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [TOTAL_BITS-1:0]  index_ff, index_in;

   value_type              lower_ff [MAX_DIMS], lower_in [MAX_DIMS];
   value_type              upper_ff [MAX_DIMS], upper_in [MAX_DIMS];
   value_type              incr_ff  [MAX_DIMS], incr_in  [MAX_DIMS];
   value_type              cur_ff   [MAX_DIMS], cur_in   [MAX_DIMS];
   logic [COUNT_BITS-1:0]  count_ff [MAX_DIMS], count_in [MAX_DIMS];
   logic [COUNT_BITS-1:0]  pos_ff   [MAX_DIMS], pos_in   [MAX_DIMS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   value_type              rsp_values_ff [MAX_DIMS], rsp_values_in [MAX_DIMS];
   logic                   rsp_is_first_ff, rsp_is_first_in;
   logic                   rsp_is_last_ff, rsp_is_last_in;
   logic                   rsp_has_next_ff, rsp_has_next_in;
   logic                   rsp_has_tuples_ff, rsp_has_tuples_in;
   logic [TOTAL_BITS-1:0]  rsp_total_ff, rsp_total_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                             cfg_write;
   logic                             req_take;
   logic                             slot_free;
   logic                             in_range;
   logic                             idx_lt;
   logic                             idx_le;
   logic                             last_dim;
   logic [ACTIVE_BITS-1:0]           cfg_dims;
   logic signed [VALUE_BITS:0]       walk_sum;
   value_type                        walk_sat;
   logic [COUNT_BITS-1:0]            pos_next;
   logic signed [VALUE_BITS:0]       bound_diff;
   logic [VALUE_BITS:0]              bound_mag;
   logic [TOTAL_BITS+COUNT_BITS-1:0] total_prod;
   logic [VALUE_BITS-1:0]            quo_neg;
   value_type                        incr_sat;

   gso_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // A configuration write takes priority, so the request channel is held off in that cycle.
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign cfg_write = csr_valid && csr_ready;
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      in_range = {1'b0, req_dim_index} < active_ff;
      idx_lt   = index_ff < total_ff;
      idx_le   = index_ff <= total_ff;
      last_dim = (ACTIVE_BITS'(dim_ff) + 1'b1) == active_ff;

      if (csr_active_dims == '0) begin
         cfg_dims = ACTIVE_BITS'(1);
      end else if (csr_active_dims > ACTIVE_BITS'(MAX_DIMS)) begin
         cfg_dims = ACTIVE_BITS'(MAX_DIMS);
      end else begin
         cfg_dims = csr_active_dims;
      end

      // Saturating add of the walked dimension's value and increment.
      walk_sum = {cur_ff[dim_ff][VALUE_BITS-1], cur_ff[dim_ff]}
               + {incr_ff[dim_ff][VALUE_BITS-1], incr_ff[dim_ff]};
      if (walk_sum[VALUE_BITS] != walk_sum[VALUE_BITS-1]) begin
         walk_sat = walk_sum[VALUE_BITS] ? VALUE_MIN : VALUE_MAX;
      end else begin
         walk_sat = walk_sum[VALUE_BITS-1:0];
      end
      pos_next = pos_ff[dim_ff] + 1'b1;

      bound_diff = {upper_ff[dim_ff][VALUE_BITS-1], upper_ff[dim_ff]}
                 - {lower_ff[dim_ff][VALUE_BITS-1], lower_ff[dim_ff]};
      bound_mag  = bound_diff[VALUE_BITS] ? -bound_diff : bound_diff;
      total_prod = total_ff * count_ff[dim_ff];

      // A negative quotient saturates only when its magnitude passes the most negative value.
      quo_neg = ~div_rsp.quotient + 1'b1;
      if (!neg_ff) begin
         incr_sat = div_rsp.quotient[VALUE_BITS-1] ? VALUE_MAX : div_rsp.quotient;
      end else if (div_rsp.quotient[VALUE_BITS-1] &&
                   (div_rsp.quotient[VALUE_BITS-2:0] != '0)) begin
         incr_sat = VALUE_MIN;
      end else begin
         incr_sat = quo_neg;
      end

      div_req.start    = (state_ff == ST_SETUP_ISSUE);
      div_req.dividend = bound_mag[VALUE_BITS-1:0];
      div_req.divisor  = (count_ff[dim_ff] <= COUNT_BITS'(1)) ? DIV_BITS'(1)
                       : DIV_BITS'(count_ff[dim_ff] - 1'b1);
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      dim_in    = dim_ff;
      ok_in     = ok_ff;
      neg_in    = neg_ff;
      total_in  = total_ff;
      index_in  = index_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      incr_in   = incr_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_ok_in         = rsp_ok_ff;
      rsp_values_in     = rsp_values_ff;
      rsp_is_first_in   = rsp_is_first_ff;
      rsp_is_last_in    = rsp_is_last_ff;
      rsp_has_next_in   = rsp_has_next_ff;
      rsp_has_tuples_in = rsp_has_tuples_ff;
      rsp_total_in      = rsp_total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cfg_write) begin
               active_in = cfg_dims;
               for (int d = 0; d < MAX_DIMS; d++) begin
                  lower_in[d] = '0;
                  upper_in[d] = '0;
                  incr_in[d]  = '0;
                  cur_in[d]   = '0;
                  count_in[d] = COUNT_BITS'(1);
                  pos_in[d]   = COUNT_BITS'(1);
               end
               total_in = TOTAL_BITS'(1);
               index_in = TOTAL_BITS'(1);
            end else if (req_take) begin
               ok_in    = 1'b0;
               state_in = ST_FINISH;
               dim_in   = '0;
               case (cmd_type'(req_command))
                  CMD_NEXT: begin
                     // The index stops one past the total once the sweep has ended.
                     ok_in = idx_lt;
                     if (idx_le) begin
                        index_in = index_ff + 1'b1;
                     end
                     if (idx_lt) begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_RESTART: begin
                     ok_in    = 1'b1;
                     total_in = TOTAL_BITS'(1);
                     state_in = ST_SETUP_ISSUE;
                  end
                  CMD_SET_LOWER, CMD_SET_UPPER, CMD_FIX_VALUE: begin
                     if (in_range) begin
                        if (cmd_type'(req_command) != CMD_SET_UPPER) begin
                           lower_in[req_dim_index] = req_value;
                        end
                        if (cmd_type'(req_command) != CMD_SET_LOWER) begin
                           upper_in[req_dim_index] = req_value;
                        end
                        if (cmd_type'(req_command) == CMD_FIX_VALUE) begin
                           count_in[req_dim_index] = COUNT_BITS'(1);
                        end
                        ok_in    = 1'b1;
                        total_in = TOTAL_BITS'(1);
                        state_in = ST_SETUP_ISSUE;
                     end
                  end
                  CMD_SET_COUNT: begin
                     if (in_range && (req_step_count != '0) &&
                         (req_step_count <= COUNT_BITS'(MAX_STEPS))) begin
                        count_in[req_dim_index] = req_step_count;
                        ok_in    = 1'b1;
                        total_in = TOTAL_BITS'(1);
                        state_in = ST_SETUP_ISSUE;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (pos_next > count_ff[dim_ff]) begin
               cur_in[dim_ff] = lower_ff[dim_ff];
               pos_in[dim_ff] = COUNT_BITS'(1);
               if (last_dim) begin
                  state_in = ST_FINISH;
               end else begin
                  dim_in = dim_ff + 1'b1;
               end
            end else begin
               cur_in[dim_ff] = walk_sat;
               pos_in[dim_ff] = pos_next;
               state_in       = ST_FINISH;
            end
         end

         ST_SETUP_ISSUE: begin
            neg_in         = bound_diff[VALUE_BITS];
            cur_in[dim_ff] = lower_ff[dim_ff];
            pos_in[dim_ff] = COUNT_BITS'(1);
            total_in       = total_prod[TOTAL_BITS-1:0];
            state_in       = ST_SETUP_WAIT;
         end

         ST_SETUP_WAIT: begin
            if (div_rsp.done) begin
               incr_in[dim_ff] = incr_sat;
               if (last_dim) begin
                  index_in = TOTAL_BITS'(1);
                  state_in = ST_FINISH;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = ST_SETUP_ISSUE;
               end
            end
         end

         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               for (int d = 0; d < MAX_DIMS; d++) begin
                  rsp_values_in[d] = (ACTIVE_BITS'(d) < active_ff) ? cur_ff[d] : '0;
               end
               rsp_is_first_in   = (index_ff == TOTAL_BITS'(1));
               rsp_is_last_in    = (index_ff == total_ff);
               rsp_has_next_in   = idx_lt;
               rsp_has_tuples_in = idx_le;
               rsp_total_in      = total_ff;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_BITS'(1);
         dim_ff       <= '0;
         ok_ff        <= 1'b0;
         neg_ff       <= 1'b0;
         total_ff     <= TOTAL_BITS'(1);
         index_ff     <= TOTAL_BITS'(1);
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            lower_ff[d] <= '0;
            upper_ff[d] <= '0;
            incr_ff[d]  <= '0;
            cur_ff[d]   <= '0;
            count_ff[d] <= COUNT_BITS'(1);
            pos_ff[d]   <= COUNT_BITS'(1);
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         dim_ff       <= dim_in;
         ok_ff        <= ok_in;
         neg_ff       <= neg_in;
         total_ff     <= total_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         incr_ff      <= incr_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
      end
      rsp_ok_ff         <= rsp_ok_in;
      rsp_values_ff     <= rsp_values_in;
      rsp_is_first_ff   <= rsp_is_first_in;
      rsp_is_last_ff    <= rsp_is_last_in;
      rsp_has_next_ff   <= rsp_has_next_in;
      rsp_has_tuples_ff <= rsp_has_tuples_in;
      rsp_total_ff      <= rsp_total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_value_0      = rsp_values_ff[0];
   assign rsp_value_1      = rsp_values_ff[1];
   assign rsp_value_2      = rsp_values_ff[2];
   assign rsp_value_3      = rsp_values_ff[3];
   assign rsp_is_first     = rsp_is_first_ff;
   assign rsp_is_last      = rsp_is_last_ff;
   assign rsp_has_next     = rsp_has_next_ff;
   assign rsp_has_tuples   = rsp_has_tuples_ff;
   assign rsp_total_tuples = rsp_total_ff;

endmodule

>>> tb/grid_sweep_odometer_tb.sv
// Self-checking testbench for the grid sweep odometer with its own sweep predictor.
`timescale 1ns / 100ps

module grid_sweep_odometer_tb;
   import gso_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_RESERVED_6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_7 = 3'd7;
   localparam value_type VALUE_MAX = 32'sh7FFF_FFFF;
   localparam value_type VALUE_MIN = 32'sh8000_0000;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_RUNS} stall_mode_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [DIM_BITS-1:0]   dim;
      value_type             value;
      logic [COUNT_BITS-1:0] count;
   } sweep_cmd_type;

   typedef struct packed {
      logic                                ok;
      logic [MAX_DIMS-1:0][VALUE_BITS-1:0] vals;
      logic                                is_first;
      logic                                is_last;
      logic                                has_next;
      logic                                has_tuples;
      logic [TOTAL_BITS-1:0]               total;
   } sweep_status_type;

   typedef struct packed {
      row_kind_type     kind;
      sweep_cmd_type    item;
      logic             typed;
      sweep_status_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [CMD_BITS-1:0]          req_command = '0;
   logic [DIM_BITS-1:0]          req_dim_index = '0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic [COUNT_BITS-1:0]        req_step_count = '0;

   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_ok;
   logic signed [VALUE_BITS-1:0] rsp_value_0;
   logic signed [VALUE_BITS-1:0] rsp_value_1;
   logic signed [VALUE_BITS-1:0] rsp_value_2;
   logic signed [VALUE_BITS-1:0] rsp_value_3;
   logic                         rsp_is_first;
   logic                         rsp_is_last;
   logic                         rsp_has_next;
   logic                         rsp_has_tuples;
   logic [TOTAL_BITS-1:0]        rsp_total_tuples;

   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [ACTIVE_BITS-1:0]       csr_active_dims = '0;

   grid_sweep_odometer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_dim_index    (req_dim_index),
      .req_value        (req_value),
      .req_step_count   (req_step_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_value_0      (rsp_value_0),
      .rsp_value_1      (rsp_value_1),
      .rsp_value_2      (rsp_value_2),
      .rsp_value_3      (rsp_value_3),
      .rsp_is_first     (rsp_is_first),
      .rsp_is_last      (rsp_is_last),
      .rsp_has_next     (rsp_has_next),
      .rsp_has_tuples   (rsp_has_tuples),
      .rsp_total_tuples (rsp_total_tuples),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_dims  (csr_active_dims)
   );

   always #5 clock = ~clock;

   // Predicted sweep state.
   int                grid_dims;
   longint            grid_lower [MAX_DIMS];
   longint            grid_upper [MAX_DIMS];
   longint            grid_inc   [MAX_DIMS];
   longint            grid_cur   [MAX_DIMS];
   int                grid_count [MAX_DIMS];
   int                grid_pos   [MAX_DIMS];
   longint unsigned   grid_total;
   longint unsigned   grid_index;

   sweep_status_type pending_status [$];
   plan_row_type     directed_plan [$];

   int mismatch_count = 0;
   int results_checked = 0;
   int items_sent = 0;
   int next_sent = 0;
   int setup_sent = 0;
   int rejected_sent = 0;
   int settings_seen = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;

   int             hold_trigger = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             holds_done = 0;
   int             mode_left = 0;
   int             tick = 0;
   stall_mode_type stall_mode = STALL_NONE;

   function automatic longint clip_value(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Loads every active value with its lower bound and recomputes steps and the tuple total.
   function automatic void rebuild_grid();
      longint span;
      grid_total = 1;
      for (int d = 0; d < grid_dims; d++) begin
         span = grid_upper[d] - grid_lower[d];
         grid_cur[d] = grid_lower[d];
         if (grid_count[d] <= 1) begin
            grid_inc[d] = clip_value(span);
         end else begin
            grid_inc[d] = clip_value(span / longint'(grid_count[d] - 1));
         end
         grid_total = (grid_total * longint'(grid_count[d])) & 64'h1FF_FFFF_FFFF;
         grid_pos[d] = 1;
      end
      grid_index = 1;
   endfunction

   function automatic logic advance_grid();
      if (grid_index <= grid_total) grid_index++;
      if (grid_index > grid_total) return 1'b0;
      for (int d = 0; d < grid_dims; d++) begin
         grid_cur[d] = clip_value(grid_cur[d] + grid_inc[d]);
         grid_pos[d]++;
         if (grid_pos[d] > grid_count[d]) begin
            grid_cur[d] = grid_lower[d];
            grid_pos[d] = 1;
         end else begin
            break;
         end
      end
      return 1'b1;
   endfunction

   function automatic void apply_active_dims(logic [ACTIVE_BITS-1:0] n);
      grid_dims = int'(n);
      if (grid_dims < 1) grid_dims = 1;
      if (grid_dims > MAX_DIMS) grid_dims = MAX_DIMS;
      for (int d = 0; d < MAX_DIMS; d++) begin
         grid_lower[d] = 0;
         grid_upper[d] = 0;
         grid_count[d] = 1;
         grid_pos[d] = 1;
         grid_inc[d] = 0;
         grid_cur[d] = 0;
      end
      rebuild_grid();
   endfunction

   function automatic sweep_status_type step_grid(sweep_cmd_type c);
      sweep_status_type r;
      logic             in_range;
      longint           v;
      r = '0;
      in_range = int'(c.dim) < grid_dims;
      v = longint'($signed(c.value));
      case (c.cmd)
         CMD_NEXT: r.ok = advance_grid();
         CMD_RESTART: begin
            rebuild_grid();
            r.ok = 1'b1;
         end
         CMD_SET_LOWER, CMD_SET_UPPER, CMD_FIX_VALUE: begin
            if (in_range) begin
               if (c.cmd != CMD_SET_UPPER) grid_lower[c.dim] = v;
               if (c.cmd != CMD_SET_LOWER) grid_upper[c.dim] = v;
               if (c.cmd == CMD_FIX_VALUE) grid_count[c.dim] = 1;
               rebuild_grid();
               r.ok = 1'b1;
            end
         end
         CMD_SET_COUNT: begin
            if (in_range && c.count != 0 && c.count <= MAX_STEPS) begin
               grid_count[c.dim] = int'(c.count);
               rebuild_grid();
               r.ok = 1'b1;
            end
         end
         default: r.ok = 1'b0;
      endcase
      for (int d = 0; d < MAX_DIMS; d++) begin
         r.vals[d] = (d < grid_dims) ? grid_cur[d][VALUE_BITS-1:0] : '0;
      end
      r.is_first   = (grid_index == 1);
      r.is_last    = (grid_index == grid_total);
      r.has_next   = (grid_index < grid_total);
      r.has_tuples = (grid_index <= grid_total);
      r.total      = grid_total[TOTAL_BITS-1:0];
      return r;
   endfunction

   // Flags are given as {is_first, is_last, has_next, has_tuples}.
   function automatic sweep_status_type known_status(logic ok, value_type v0, logic [3:0] flags,
                                                     logic [TOTAL_BITS-1:0] total);
      sweep_status_type r;
      r = '0;
      r.ok = ok;
      r.vals[0] = v0;
      {r.is_first, r.is_last, r.has_next, r.has_tuples} = flags;
      r.total = total;
      return r;
   endfunction

   function automatic void add_row(row_kind_type kind, logic [CMD_BITS-1:0] cmd,
                                   logic [DIM_BITS-1:0] dim, value_type value,
                                   logic [COUNT_BITS-1:0] count, logic typed,
                                   sweep_status_type want);
      plan_row_type row;
      row.kind = kind;
      row.item = '{cmd: cmd, dim: dim, value: value, count: count};
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endfunction

   function automatic value_type pick_value();
      int s;
      case ($urandom_range(0, 5))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return value_type'($urandom);
         default: begin
            // A few tens in either direction, with a fraction part.
            s = int'($urandom_range(0, 1 << 22)) - (1 << 21);
            return value_type'(s);
         end
      endcase
   endfunction

   function automatic logic [COUNT_BITS-1:0] pick_count();
      if ($urandom_range(0, 15) == 0) return COUNT_BITS'($urandom_range(6, MAX_STEPS));
      return COUNT_BITS'($urandom_range(1, (grid_dims > 2) ? 3 : 6));
   endfunction

   function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $time, field, want, got);
      end
   endfunction

   task automatic offer_item(sweep_cmd_type c, logic typed, sweep_status_type typed_want);
      sweep_status_type predicted;
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_command    <= c.cmd;
      req_dim_index  <= c.dim;
      req_value      <= c.value;
      req_step_count <= c.count;
      do @(posedge clock); while (req_stall);
      predicted = step_grid(c);
      pending_status.push_back(typed ? typed_want : predicted);
      items_sent++;
      if (c.cmd == CMD_NEXT) next_sent++;
      else if (c.cmd <= CMD_FIX_VALUE) setup_sent++;
      if (!(typed ? typed_want.ok : predicted.ok)) rejected_sent++;
   endtask

   task automatic send(logic [CMD_BITS-1:0] cmd, logic [DIM_BITS-1:0] dim, value_type value,
                       logic [COUNT_BITS-1:0] count);
      offer_item('{cmd: cmd, dim: dim, value: value, count: count}, 1'b0, '0);
   endtask

   task automatic wait_for_drain(int limit);
      int waited;
      waited = 0;
      while (pending_status.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_active_dims(logic [ACTIVE_BITS-1:0] n);
      req_valid <= 1'b0;
      wait_for_drain(20000);
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_active_dims <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_active_dims(n);
      burst_left = 0;
      settings_seen++;
   endtask

   task automatic random_phase(int quota);
      int                  first_item;
      int                  roll;
      int                  walk;
      logic [DIM_BITS-1:0] dim;
      first_item = items_sent;
      while (items_sent - first_item < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            // Well-formed set-up of every active dimension, then a walk over the grid.
            for (int d = 0; d < grid_dims; d++) begin
               if ($urandom_range(0, 4) == 0) begin
                  send(CMD_FIX_VALUE, DIM_BITS'(d), pick_value(), COUNT_BITS'($urandom));
               end else begin
                  if ($urandom_range(0, 3) != 0) begin
                     send(CMD_SET_LOWER, DIM_BITS'(d), pick_value(), COUNT_BITS'($urandom));
                  end
                  if ($urandom_range(0, 3) != 0) begin
                     send(CMD_SET_UPPER, DIM_BITS'(d), pick_value(), COUNT_BITS'($urandom));
                  end
                  send(CMD_SET_COUNT, DIM_BITS'(d), value_type'($urandom), pick_count());
               end
            end
            if ($urandom_range(0, 2) == 0) begin
               send(CMD_RESTART, DIM_BITS'($urandom), value_type'($urandom),
                    COUNT_BITS'($urandom));
            end
            if (grid_total <= 60) walk = int'(grid_total) + $urandom_range(0, 2);
            else walk = $urandom_range(4, 30);
            // The walk ends early once the phase has sent its share.
            for (int k = 0; k < walk && items_sent - first_item < quota; k++) begin
               send(CMD_NEXT, DIM_BITS'($urandom), value_type'($urandom),
                    COUNT_BITS'($urandom));
            end
         end else if (roll < 85) begin
            send(CMD_BITS'($urandom), DIM_BITS'($urandom), value_type'($urandom),
                 COUNT_BITS'($urandom));
         end else begin
            // Broken set-up: a bad count, or an inactive dimension when one exists.
            if (grid_dims < MAX_DIMS) dim = DIM_BITS'($urandom_range(grid_dims, MAX_DIMS - 1));
            else dim = DIM_BITS'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               send(CMD_SET_COUNT, DIM_BITS'($urandom), value_type'($urandom),
                    ($urandom_range(0, 1) == 0) ? '0
                    : COUNT_BITS'($urandom_range(MAX_STEPS + 1, 2047)));
            end else begin
               send(($urandom_range(0, 1) == 0) ? CMD_SET_LOWER : CMD_FIX_VALUE, dim,
                    pick_value(), pick_count());
            end
            repeat ($urandom_range(1, 4)) begin
               send(CMD_NEXT, DIM_BITS'($urandom), value_type'($urandom),
                    COUNT_BITS'($urandom));
            end
         end
      end
   endtask

   // Receiver: shifting stall patterns, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
         if (hold_left == 0) holds_done++;
      end else if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         tick++;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= (tick % 3 == 0);
            default:        rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : result_check
      sweep_status_type got;
      sweep_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.ok         = rsp_ok;
         got.vals[0]    = rsp_value_0;
         got.vals[1]    = rsp_value_1;
         got.vals[2]    = rsp_value_2;
         got.vals[3]    = rsp_value_3;
         got.is_first   = rsp_is_first;
         got.is_last    = rsp_is_last;
         got.has_next   = rsp_has_next;
         got.has_tuples = rsp_has_tuples;
         got.total      = rsp_total_tuples;
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("%0t: result with no transaction pending", $time);
         end else begin
            want = pending_status.pop_front();
            results_checked++;
            if (got.ok !== want.ok) flag_field("ok", 64'(want.ok), 64'(got.ok));
            for (int d = 0; d < MAX_DIMS; d++) begin
               if (got.vals[d] !== want.vals[d]) begin
                  flag_field($sformatf("value_%0d", d), 64'(want.vals[d]), 64'(got.vals[d]));
               end
            end
            if (got.is_first !== want.is_first) begin
               flag_field("is_first", 64'(want.is_first), 64'(got.is_first));
            end
            if (got.is_last !== want.is_last) begin
               flag_field("is_last", 64'(want.is_last), 64'(got.is_last));
            end
            if (got.has_next !== want.has_next) begin
               flag_field("has_next", 64'(want.has_next), 64'(got.has_next));
            end
            if (got.has_tuples !== want.has_tuples) begin
               flag_field("has_tuples", 64'(want.has_tuples), 64'(got.has_tuples));
            end
            if (got.total !== want.total) begin
               flag_field("total_tuples", 64'(want.total), 64'(got.total));
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", pending_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int dims_plan [8];
      dims_plan = '{0, 3, 7, 2, 4, 1, 5, 6};

      // One active dimension after reset.
      add_row(ROW_ITEM, CMD_NEXT, 0, 0, 0, 1'b1, known_status(1'b0, 0, 4'b0000, 1));
      add_row(ROW_ITEM, CMD_RESTART, 0, 0, 0, 1'b1, known_status(1'b1, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_RESERVED_6, 1, 32'h1234_5678, 5, 1'b1,
              known_status(1'b0, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_RESERVED_7, 3, 32'hFFFF_FFFF, 2047, 1'b1,
              known_status(1'b0, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_SET_LOWER, 3, 32'h1234_5678, 1, 1'b1,
              known_status(1'b0, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_SET_COUNT, 0, 0, 0, 1'b1, known_status(1'b0, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_SET_COUNT, 0, 0, COUNT_BITS'(MAX_STEPS + 1), 1'b1,
              known_status(1'b0, 0, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_SET_LOWER, 0, VALUE_MIN, 0, 1'b1,
              known_status(1'b1, VALUE_MIN, 4'b1101, 1));
      add_row(ROW_ITEM, CMD_SET_UPPER, 0, VALUE_MAX, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 0, 0, 2, 1'b0, '0);
      add_row(ROW_ITEM, CMD_NEXT, 0, 0, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_NEXT, 0, 0, 0, 1'b0, '0);
      // All four dimensions at the largest grid, then a small grid walked with carries.
      add_row(ROW_CSR, CMD_NEXT, 0, 7, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 3, 0, COUNT_BITS'(MAX_STEPS), 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 2, 0, COUNT_BITS'(MAX_STEPS), 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 1, 0, COUNT_BITS'(MAX_STEPS), 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 0, 0, COUNT_BITS'(MAX_STEPS), 1'b1,
              known_status(1'b1, 0, 4'b1011, 41'h100_0000_0000));
      add_row(ROW_ITEM, CMD_FIX_VALUE, 3, 32'hFFFF_8000, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_FIX_VALUE, 2, VALUE_MAX, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_UPPER, 1, 32'h0003_0000, 0, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 1, 0, 3, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_COUNT, 0, 0, 2, 1'b0, '0);
      add_row(ROW_ITEM, CMD_SET_LOWER, 0, 32'hFFFF_0000, 0, 1'b0, '0);
      repeat (4) add_row(ROW_ITEM, CMD_NEXT, 0, 0, 0, 1'b0, '0);

      apply_active_dims(1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            write_active_dims(directed_plan[i].item.value[ACTIVE_BITS-1:0]);
         end else begin
            offer_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      for (int p = 0; p < 8; p++) begin
         write_active_dims(dims_plan[p][ACTIVE_BITS-1:0]);
         gaps_on = (p % 3 != 1);
         // Hold the result side off while the sender keeps offering, to back the block up.
         if (p == 2) hold_trigger++;
         random_phase(50);
      end

      req_valid <= 1'b0;
      wait_for_drain(20000);
      repeat (50) @(posedge clock);
      if (pending_status.size() != 0) begin
         mismatch_count += pending_status.size();
         $display("%0d expected results never arrived", pending_status.size());
      end

      $display("Covered %0d transactions: %0d next, %0d set-up or restart, %0d refused",
               items_sent, next_sent, setup_sent, rejected_sent);
      $display("%0d results checked over %0d dimension settings, %0d long hold-offs, %0d mismatches",
               results_checked, settings_seen, holds_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/gso_pkg.sv
sv/gso_divider.sv
sv/grid_sweep_odometer.sv
tb/grid_sweep_odometer_tb.sv
